// ===== hdl/tav_pkg.sv =====
// Shared types and constants for the triangle box voxel marker.
// Holds the payload structs, the controller/datapath link and the code constants.
// No dependencies.
package tav_pkg;

  localparam int unsigned MaxResDefault = 64;
  localparam int unsigned WordBits      = 64;
  localparam int unsigned BitSelW       = 6;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned CellW         = 31;
  localparam int unsigned ResCfgW       = 7;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned KindW         = 2;
  localparam int unsigned WordIdxW      = 12;
  localparam int unsigned TestedW       = 48;
  localparam int unsigned OccW          = 19;

  localparam logic [KindW-1:0] KindMark  = 2'd0;
  localparam logic [KindW-1:0] KindRead  = 2'd1;
  localparam logic [KindW-1:0] KindClear = 2'd2;

  localparam logic [CfgIdxW-1:0] RegRes   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinX  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinY  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinZ  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCellX = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCellY = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCellZ = 3'd6;

  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v0_z;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
    logic [WordIdxW-1:0]      word_index;
  } in_item_t;

  typedef struct packed {
    logic [WordBits-1:0] grid_word;
    logic [TestedW-1:0]  tested_count;
    logic [OccW-1:0]     occupied_count;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic clr_step;
    logic cnt_clear;
    logic div_load;
    logic div_step;
    logic div_store;
    logic setup1;
    logic setup2;
    logic setup3;
    logic mem_rd;
    logic mem_wr;
    logic next_word;
    logic next_row;
    logic next_plane;
    logic rd_req;
    logic rd_cap;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             clr_last;
    logic             div_last_step;
    logic             div_last_op;
    logic             word_last;
    logic             y_last;
    logic             z_last;
    logic             out_free;
  } sts_t;

endpackage

// ===== hdl/triangle_aabb_voxel_marker.sv =====
// Top level of the triangle box voxel marker.
// Joins the controller and the datapath. Depends on tav_pkg, tav_ctrl, tav_dp.
//
// Input channel in_valid_i/in_ready_o carries one item: mark a triangle box,
// read one 64-bit grid word, or clear grid and counts. Every item gives one
// result on out_valid_o/out_ready_i with the grid word and both counts.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i). The
// user must use it only while the block is idle; the block does not check.
// Items are handled one at a time. A mark runs the shared divider for each of
// the six box bounds, then walks the grid words touched by the box rows; each
// word is one read and one write on the single-port grid memory. A read asks
// for one word and captures it; a clear zeroes the grid one word per cycle.
// A kind-3 item only returns a result.
// After reset the grid is cleared in a pass over all GridWords words (4096
// at the default size), during which in_ready_o stays low.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and runs, and its result waits until that register frees.
module triangle_aabb_voxel_marker #(
  parameter int unsigned MAX_RESOLUTION = tav_pkg::MaxResDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tav_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tav_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tav_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tav_pkg::out_item_t           out_item_o
);
  import tav_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tav_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tav_dp #(.MAX_RESOLUTION(MAX_RESOLUTION)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== hdl/tav_div.sv =====
// Restoring divider that turns a coordinate offset into a clamped cell index.
// One quotient bit per cycle; the top step only detects overflow.
// Depends on tav_pkg.
module tav_div #(
  parameter int unsigned QW = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic signed [tav_pkg::CoordW:0] num_i,
  input  logic [tav_pkg::CellW-1:0]   den_i,
  input  logic [QW-1:0]               lim_i,
  output logic                        last_o,
  output logic [QW-1:0]               quot_o
);
  import tav_pkg::*;

  localparam int unsigned KW = $clog2(QW + 1);
  localparam int unsigned TW = CoordW + QW + 1;

  logic [CoordW-1:0] rem_q, rem_d;
  logic [KW-1:0]     k_q, k_d;
  logic [QW-1:0]     q_q, q_d;
  logic              sat_q, sat_d;
  logic [CellW-1:0]  den_eff;
  logic [TW-1:0]     rem_ext, den_sh, diff;

  assign den_eff = (den_i == '0) ? CellW'(1) : den_i;
  assign rem_ext = TW'(rem_q);
  assign den_sh  = TW'(den_eff) << k_q;
  assign diff    = rem_ext - den_sh;

  always_comb begin
    rem_d = rem_q;
    k_d   = k_q;
    q_d   = q_q;
    sat_d = sat_q;
    if (load_i) begin
      rem_d = num_i[CoordW] ? '0 : num_i[CoordW-1:0];
      k_d   = KW'(QW);
      q_d   = '0;
      sat_d = 1'b0;
    end else if (step_i) begin
      if (rem_ext >= den_sh) begin
        rem_d = diff[CoordW-1:0];
        if (k_q == KW'(QW)) begin
          sat_d = 1'b1;
        end else begin
          q_d = q_q | (QW'(1) << k_q);
        end
      end
      if (k_q != '0) begin
        k_d = k_q - KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      k_q   <= '0;
      q_q   <= '0;
      sat_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      k_q   <= k_d;
      q_q   <= q_d;
      sat_q <= sat_d;
    end
  end

  assign last_o = (k_q == '0);
  assign quot_o = (sat_q || (q_q > lim_i)) ? lim_i : q_q;

endmodule

// ===== hdl/tav_ctrl.sv =====
// Controller state machine of the voxel marker.
// Sequences bounds division, box walk, grid read, grid clear and result transfer.
// Depends on tav_pkg.
module tav_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tav_pkg::sts_t sts_i,
  output tav_pkg::cmd_t cmd_o
);
  import tav_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIVLD = 4'd2;
  localparam logic [3:0] S_DIVST = 4'd3;
  localparam logic [3:0] S_DIVWB = 4'd4;
  localparam logic [3:0] S_SU1   = 4'd5;
  localparam logic [3:0] S_SU2   = 4'd6;
  localparam logic [3:0] S_SU3   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_RDREQ = 4'd10;
  localparam logic [3:0] S_RDCAP = 4'd11;
  localparam logic [3:0] S_CLR   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          case (sts_i.kind)
            KindMark:  state_d = S_DIVLD;
            KindRead:  state_d = S_RDREQ;
            KindClear: state_d = S_CLR;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_DIVLD: begin
        cmd_o.div_load = 1'b1;
        state_d = S_DIVST;
      end
      S_DIVST: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last_step) state_d = S_DIVWB;
      end
      S_DIVWB: begin
        cmd_o.div_store = 1'b1;
        state_d = sts_i.div_last_op ? S_SU1 : S_DIVLD;
      end
      S_SU1: begin
        cmd_o.setup1 = 1'b1;
        state_d = S_SU2;
      end
      S_SU2: begin
        cmd_o.setup2 = 1'b1;
        state_d = S_SU3;
      end
      S_SU3: begin
        cmd_o.setup3 = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        cmd_o.mem_wr = 1'b1;
        if (!sts_i.word_last) begin
          cmd_o.next_word = 1'b1;
          state_d = S_RD;
        end else if (!sts_i.y_last) begin
          cmd_o.next_row = 1'b1;
          state_d = S_RD;
        end else if (!sts_i.z_last) begin
          cmd_o.next_plane = 1'b1;
          state_d = S_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RDREQ: begin
        cmd_o.rd_req = 1'b1;
        state_d = S_RDCAP;
      end
      S_RDCAP: begin
        cmd_o.rd_cap = 1'b1;
        state_d = S_DONE;
      end
      S_CLR: begin
        cmd_o.clr_step  = 1'b1;
        cmd_o.cnt_clear = 1'b1;
        if (sts_i.clr_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("result transfer into a full output stage");
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == S_IDLE)) else $error("no return to idle after result");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> !in_ready_o) else $error("new item taken while one is in flight");
`endif

endmodule

// ===== hdl/tav_dp.sv =====
// Datapath of the voxel marker: configuration, bounds, divider, box walk,
// bit grid memory, counters and output stage.
// Depends on tav_pkg and tav_div.
module tav_dp #(
  parameter int unsigned MAX_RESOLUTION = tav_pkg::MaxResDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tav_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tav_pkg::CfgDataW-1:0]   cfg_data_i,
  input  tav_pkg::in_item_t              in_item_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output tav_pkg::out_item_t             out_item_o,
  input  tav_pkg::cmd_t                  cmd_i,
  output tav_pkg::sts_t                  sts_o
);
  import tav_pkg::*;

  localparam int unsigned GridWords = (MAX_RESOLUTION * MAX_RESOLUTION * MAX_RESOLUTION
                                       + WordBits - 1) / WordBits;
  localparam int unsigned AddrW = (GridWords > 1) ? $clog2(GridWords) : 1;
  localparam int unsigned QW    = (MAX_RESOLUTION > 1) ? $clog2(MAX_RESOLUTION) : 1;
  localparam int unsigned RW    = $clog2(MAX_RESOLUTION + 1);
  localparam int unsigned IdxW  = AddrW + BitSelW;
  localparam int unsigned DimW  = QW + 1;
  localparam int unsigned RrW   = 2 * RW;
  localparam int unsigned LrW   = QW + RW;
  localparam int unsigned VolW  = 3 * DimW;
  localparam int unsigned PcW   = BitSelW + 1;

  // configuration
  logic [ResCfgW-1:0]       res_cfg_q;
  logic signed [CoordW-1:0] gmin_q [3];
  logic [CellW-1:0]         cell_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cfg_q <= ResCfgW'(MaxResDefault);
      gmin_q[0] <= '0;
      gmin_q[1] <= '0;
      gmin_q[2] <= '0;
      cell_q[0] <= CellW'(65536);
      cell_q[1] <= CellW'(65536);
      cell_q[2] <= CellW'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRes:   res_cfg_q <= cfg_data_i[ResCfgW-1:0];
        RegMinX:  gmin_q[0] <= cfg_data_i;
        RegMinY:  gmin_q[1] <= cfg_data_i;
        RegMinZ:  gmin_q[2] <= cfg_data_i;
        RegCellX: cell_q[0] <= cfg_data_i[CellW-1:0];
        RegCellY: cell_q[1] <= cfg_data_i[CellW-1:0];
        RegCellZ: cell_q[2] <= cfg_data_i[CellW-1:0];
        default: ;
      endcase
    end
  end

  logic [RW-1:0] res_eff;
  always_comb begin
    if (res_cfg_q == '0) begin
      res_eff = RW'(1);
    end else if (32'(res_cfg_q) > 32'(MAX_RESOLUTION)) begin
      res_eff = RW'(MAX_RESOLUTION);
    end else begin
      res_eff = RW'(res_cfg_q);
    end
  end

  // item capture and bounds division
  in_item_t         item_q;
  logic [2:0]       op_q;
  logic [QW-1:0]    lo_q [3];
  logic [QW-1:0]    hi_q [3];
  logic [1:0]       axis;
  logic signed [CoordW-1:0] c0, c1, c2, cmin, cmax, csel;
  logic signed [CoordW:0]   num;
  logic [QW-1:0]    lim, quot;
  logic             div_last;

  assign axis = op_q[2:1];
  assign lim  = QW'(res_eff - RW'(1));

  always_comb begin
    case (axis)
      2'd0: begin c0 = item_q.v0_x; c1 = item_q.v1_x; c2 = item_q.v2_x; end
      2'd1: begin c0 = item_q.v0_y; c1 = item_q.v1_y; c2 = item_q.v2_y; end
      default: begin c0 = item_q.v0_z; c1 = item_q.v1_z; c2 = item_q.v2_z; end
    endcase
    cmin = c0;
    cmax = c0;
    if (c1 < cmin) cmin = c1;
    if (c1 > cmax) cmax = c1;
    if (c2 < cmin) cmin = c2;
    if (c2 > cmax) cmax = c2;
    csel = op_q[0] ? cmax : cmin;
    num  = (CoordW + 1)'(csel) - (CoordW + 1)'(gmin_q[axis]);
  end

  tav_div #(.QW(QW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cmd_i.div_load),
    .step_i (cmd_i.div_step),
    .num_i  (num),
    .den_i  (cell_q[axis]),
    .lim_i  (lim),
    .last_o (div_last),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else if (cmd_i.take) begin
      op_q <= '0;
    end else if (cmd_i.div_store) begin
      op_q <= op_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) item_q <= in_item_i;
    if (cmd_i.div_store) begin
      if (op_q[0]) hi_q[axis] <= quot;
      else         lo_q[axis] <= quot;
    end
  end

  // box walk
  logic [RrW-1:0]  rr_q;
  logic [LrW-1:0]  lr_q;
  logic [VolW-1:0] vol_q;
  logic [IdxW-1:0] plane_q, row_q, cur_q, end_q;
  logic [QW-1:0]   y_q, z_q;
  logic [DimW-1:0] dx, dy, dz;
  logic [IdxW-1:0] row_nr, plane_np, row_np;
  logic [AddrW-1:0] cur_word, end_word;
  logic            word_last;

  assign dx = DimW'(hi_q[0]) - DimW'(lo_q[0]) + DimW'(1);
  assign dy = DimW'(hi_q[1]) - DimW'(lo_q[1]) + DimW'(1);
  assign dz = DimW'(hi_q[2]) - DimW'(lo_q[2]) + DimW'(1);

  assign cur_word  = cur_q[IdxW-1:BitSelW];
  assign end_word  = end_q[IdxW-1:BitSelW];
  assign word_last = (cur_word == end_word);
  assign row_nr    = row_q + IdxW'(res_eff);
  assign plane_np  = plane_q + IdxW'(rr_q);
  assign row_np    = plane_np + IdxW'(lr_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup1) begin
      rr_q  <= RrW'(res_eff) * RrW'(res_eff);
      lr_q  <= LrW'(lo_q[1]) * LrW'(res_eff);
      vol_q <= VolW'(dx) * VolW'(dy);
    end
    if (cmd_i.setup2) begin
      plane_q <= IdxW'(lo_q[2]) * IdxW'(rr_q);
      vol_q   <= vol_q * VolW'(dz);
    end
    if (cmd_i.setup3) begin
      row_q <= plane_q + IdxW'(lr_q);
      cur_q <= plane_q + IdxW'(lr_q) + IdxW'(lo_q[0]);
      end_q <= plane_q + IdxW'(lr_q) + IdxW'(hi_q[0]);
      y_q   <= lo_q[1];
      z_q   <= lo_q[2];
    end
    if (cmd_i.next_word) begin
      cur_q <= {cur_word + AddrW'(1), BitSelW'(0)};
    end
    if (cmd_i.next_row) begin
      row_q <= row_nr;
      cur_q <= row_nr + IdxW'(lo_q[0]);
      end_q <= row_nr + IdxW'(hi_q[0]);
      y_q   <= y_q + QW'(1);
    end
    if (cmd_i.next_plane) begin
      plane_q <= plane_np;
      row_q   <= row_np;
      cur_q   <= row_np + IdxW'(lo_q[0]);
      end_q   <= row_np + IdxW'(hi_q[0]);
      y_q     <= lo_q[1];
      z_q     <= z_q + QW'(1);
    end
  end

  // grid memory
  logic [WordBits-1:0] mem_q [GridWords];
  logic [WordBits-1:0] rdata_q;
  logic [AddrW-1:0]    clr_addr_q;
  logic                clr_last;
  logic                mem_we, mem_re;
  logic [AddrW-1:0]    waddr, raddr;
  logic [WordBits-1:0] wdata, mask, fresh;
  logic [BitSelW-1:0]  hi_bit;
  logic [31:0]         wi_ext;
  logic                wi_ok;

  assign clr_last = (clr_addr_q == AddrW'(GridWords - 1));
  assign hi_bit   = word_last ? end_q[BitSelW-1:0] : BitSelW'(WordBits - 1);
  assign mask     = ({WordBits{1'b1}} << cur_q[BitSelW-1:0])
                  & ({WordBits{1'b1}} >> (BitSelW'(WordBits - 1) - hi_bit));
  assign fresh    = mask & ~rdata_q;
  assign wi_ext   = 32'(item_q.word_index);
  assign wi_ok    = (wi_ext < 32'(GridWords));

  assign mem_we = cmd_i.clr_step | cmd_i.mem_wr;
  assign waddr  = cmd_i.clr_step ? clr_addr_q : cur_word;
  assign wdata  = cmd_i.clr_step ? '0 : (rdata_q | mask);
  assign mem_re = cmd_i.mem_rd | cmd_i.rd_req;
  assign raddr  = cmd_i.rd_req ? wi_ext[AddrW-1:0] : cur_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    if (mem_re) rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_last ? '0 : clr_addr_q + AddrW'(1);
    end
  end

  // counters
  logic [PcW-1:0]     pc;
  logic [TestedW-1:0] tested_q;
  logic [OccW-1:0]    occ_q;
  logic [TestedW:0]   tested_sum;
  logic [OccW:0]      occ_sum;

  always_comb begin
    pc = '0;
    for (int i = 0; i < WordBits; i++) begin
      pc = pc + PcW'(fresh[i]);
    end
  end

  assign tested_sum = {1'b0, tested_q} + (TestedW + 1)'(vol_q);
  assign occ_sum    = {1'b0, occ_q} + (OccW + 1)'(pc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tested_q <= '0;
      occ_q    <= '0;
    end else if (cmd_i.cnt_clear) begin
      tested_q <= '0;
      occ_q    <= '0;
    end else begin
      if (cmd_i.setup3) begin
        tested_q <= tested_sum[TestedW] ? '1 : tested_sum[TestedW-1:0];
      end
      if (cmd_i.mem_wr) begin
        occ_q <= occ_sum[OccW] ? '1 : occ_sum[OccW-1:0];
      end
    end
  end

  // result word and output stage
  logic [WordBits-1:0] word_q;
  logic                out_valid_q;
  out_item_t           out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take)   word_q <= '0;
    if (cmd_i.rd_cap) word_q <= wi_ok ? rdata_q : '0;
    if (cmd_i.emit) begin
      out_q.grid_word      <= word_q;
      out_q.tested_count   <= tested_q;
      out_q.occupied_count <= occ_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign sts_o.kind          = in_item_i.kind;
  assign sts_o.clr_last      = clr_last;
  assign sts_o.div_last_step = div_last;
  assign sts_o.div_last_op   = (op_q == 3'd5);
  assign sts_o.word_last     = word_last;
  assign sts_o.y_last        = (y_q == hi_q[1]);
  assign sts_o.z_last        = (z_q == hi_q[2]);
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_occ_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.cnt_clear |=> occ_q >= $past(occ_q)) else $error("occupied count fell");
  a_tested_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.cnt_clear |=> tested_q >= $past(tested_q)) else $error("tested count fell");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_step && cmd_i.mem_wr)) else $error("clear and mark write collide");
`endif

endmodule
